### rtl/core/xid_pkg.sv
`timescale 1ns / 1ps

package xid_pkg;

  // Opcode bytes
  localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
  localparam logic [7:0] OP_LOAD     = 8'hA1;
  localparam logic [7:0] OP_STORE    = 8'hA3;
  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_PUSH_EAX = 8'h50;
  localparam logic [7:0] OP_POP_EAX  = 8'h58;
  localparam logic [7:0] OP_POP_ECX  = 8'h59;
  localparam logic [7:0] OP_POP_EBX  = 8'h5B;
  localparam logic [7:0] OP_PUSH_EBP = 8'h55;
  localparam logic [7:0] OP_LEAVE    = 8'hC9;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] OP_INT      = 8'hCD;
  localparam logic [7:0] OP_MOV_RM   = 8'h89;
  localparam logic [7:0] OP_MOV_MR   = 8'h8B;
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_SUB      = 8'h29;
  localparam logic [7:0] OP_CMP      = 8'h39;

  // Second bytes (escape opcode, interrupt vector, ModRM)
  localparam logic [7:0] OP2_JZ        = 8'h84;
  localparam logic [7:0] VEC_SYSCALL   = 8'h80;
  localparam logic [7:0] MODRM_EBP_ESP = 8'hE5;
  localparam logic [7:0] MODRM_EBP_D8  = 8'h45;
  localparam logic [7:0] MODRM_EAX_ECX = 8'hC8;
  localparam logic [7:0] MODRM_EDX_EAX = 8'hC2;
  localparam logic [7:0] MODRM_ECX_EAX = 8'hC1;

  typedef logic [4:0] code_t;
  typedef logic [2:0] len_t;

  // Instruction codes
  localparam code_t IC_DATA         = 5'd0;
  localparam code_t IC_MOV_IMM      = 5'd1;
  localparam code_t IC_LOAD         = 5'd2;
  localparam code_t IC_STORE        = 5'd3;
  localparam code_t IC_CALL         = 5'd4;
  localparam code_t IC_JMP          = 5'd5;
  localparam code_t IC_JZ           = 5'd6;
  localparam code_t IC_PUSH_EAX     = 5'd7;
  localparam code_t IC_POP_EAX      = 5'd8;
  localparam code_t IC_POP_ECX      = 5'd9;
  localparam code_t IC_POP_EBX      = 5'd10;
  localparam code_t IC_PUSH_EBP     = 5'd11;
  localparam code_t IC_LEAVE        = 5'd12;
  localparam code_t IC_RET          = 5'd13;
  localparam code_t IC_INT80        = 5'd14;
  localparam code_t IC_MOV_EBP_ESP  = 5'd15;
  localparam code_t IC_STORE_EBP    = 5'd16;
  localparam code_t IC_LOAD_EBP     = 5'd17;
  localparam code_t IC_MOV_EAX_ECX  = 5'd18;
  localparam code_t IC_MOV_EDX_EAX  = 5'd19;
  localparam code_t IC_ADD_EAX_ECX  = 5'd20;
  localparam code_t IC_SUB_ECX_EAX  = 5'd21;
  localparam code_t IC_CMP_ECX_EAX  = 5'd22;

  // Input beat, laid out as in in_tdata (lowest field last)
  typedef struct packed {
    logic [31:0] addr;
    len_t        left;
    logic [7:0]  b5;
    logic [7:0]  b4;
    logic [7:0]  b3;
    logic [7:0]  b2;
    logic [7:0]  b1;
    logic [7:0]  b0;
  } win_t;

  // Decoded item between stages; addr turns into addr + len after stage two
  typedef struct packed {
    code_t       code;
    len_t        len;
    logic        has;
    logic        branch;
    logic [31:0] disp;
    logic [31:0] addr;
  } dec_t;

  // Result beat, laid out as in out_tdata
  typedef struct packed {
    logic        has;
    logic [31:0] operand;
    len_t        len;
    code_t       code;
  } res_t;

endpackage

### rtl/core/xid_classify.sv
`timescale 1ns / 1ps

module xid_classify (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  output logic          s_ready,
  input  xid_pkg::win_t s_win,
  output logic          m_valid,
  input  logic          m_ready,
  output xid_pkg::dec_t m_dec
);
  import xid_pkg::*;

  logic        valid_r;
  dec_t        dec_r;
  dec_t        dec_nxt;
  code_t       code;
  len_t        len;
  logic        fits5;
  logic        fits6;
  logic        fits2;
  logic        fits3;
  logic [31:0] imm1;
  logic [31:0] imm2;

  assign fits2 = s_win.left >= 3'd2;
  assign fits3 = s_win.left >= 3'd3;
  assign fits5 = s_win.left >= 3'd5;
  assign fits6 = s_win.left >= 3'd6;
  assign imm1  = {s_win.b4, s_win.b3, s_win.b2, s_win.b1};
  assign imm2  = {s_win.b5, s_win.b4, s_win.b3, s_win.b2};

  // Match forms in priority order; a form wins only if all its bytes are valid
  always_comb begin
    code = IC_DATA;
    len  = 3'd1;
    priority if (s_win.b0 == OP_MOV_IMM && fits5) begin
      code = IC_MOV_IMM;     len = 3'd5;
    end else if (s_win.b0 == OP_LOAD && fits5) begin
      code = IC_LOAD;        len = 3'd5;
    end else if (s_win.b0 == OP_STORE && fits5) begin
      code = IC_STORE;       len = 3'd5;
    end else if (s_win.b0 == OP_CALL && fits5) begin
      code = IC_CALL;        len = 3'd5;
    end else if (s_win.b0 == OP_JMP && fits5) begin
      code = IC_JMP;         len = 3'd5;
    end else if (s_win.b0 == OP_ESC && s_win.b1 == OP2_JZ && fits6) begin
      code = IC_JZ;          len = 3'd6;
    end else if (s_win.b0 == OP_PUSH_EAX) begin
      code = IC_PUSH_EAX;
    end else if (s_win.b0 == OP_POP_EAX) begin
      code = IC_POP_EAX;
    end else if (s_win.b0 == OP_POP_ECX) begin
      code = IC_POP_ECX;
    end else if (s_win.b0 == OP_POP_EBX) begin
      code = IC_POP_EBX;
    end else if (s_win.b0 == OP_PUSH_EBP) begin
      code = IC_PUSH_EBP;
    end else if (s_win.b0 == OP_LEAVE) begin
      code = IC_LEAVE;
    end else if (s_win.b0 == OP_RET) begin
      code = IC_RET;
    end else if (s_win.b0 == OP_INT && fits2 && s_win.b1 == VEC_SYSCALL) begin
      code = IC_INT80;       len = 3'd2;
    end else if (s_win.b0 == OP_MOV_RM && fits2 && s_win.b1 == MODRM_EBP_ESP) begin
      code = IC_MOV_EBP_ESP; len = 3'd2;
    end else if (s_win.b0 == OP_MOV_RM && fits3 && s_win.b1 == MODRM_EBP_D8) begin
      code = IC_STORE_EBP;   len = 3'd3;
    end else if (s_win.b0 == OP_MOV_MR && fits3 && s_win.b1 == MODRM_EBP_D8) begin
      code = IC_LOAD_EBP;    len = 3'd3;
    end else if (s_win.b0 == OP_MOV_RM && fits2 && s_win.b1 == MODRM_EAX_ECX) begin
      code = IC_MOV_EAX_ECX; len = 3'd2;
    end else if (s_win.b0 == OP_MOV_RM && fits2 && s_win.b1 == MODRM_EDX_EAX) begin
      code = IC_MOV_EDX_EAX; len = 3'd2;
    end else if (s_win.b0 == OP_ADD && fits2 && s_win.b1 == MODRM_EAX_ECX) begin
      code = IC_ADD_EAX_ECX; len = 3'd2;
    end else if (s_win.b0 == OP_SUB && fits2 && s_win.b1 == MODRM_ECX_EAX) begin
      code = IC_SUB_ECX_EAX; len = 3'd2;
    end else if (s_win.b0 == OP_CMP && fits2 && s_win.b1 == MODRM_ECX_EAX) begin
      code = IC_CMP_ECX_EAX; len = 3'd2;
    end else begin
      code = IC_DATA;        len = 3'd1;
    end
  end

  // Pick the operand source; data bytes carry the opcode, register forms zero
  always_comb begin
    dec_nxt.code   = code;
    dec_nxt.len    = len;
    dec_nxt.has    = code <= IC_JZ;
    dec_nxt.branch = code == IC_CALL || code == IC_JMP || code == IC_JZ;
    dec_nxt.addr   = s_win.addr;
    if (code == IC_JZ) begin
      dec_nxt.disp = imm2;
    end else if (code == IC_DATA) begin
      dec_nxt.disp = {24'h0, s_win.b0};
    end else if (code <= IC_JMP) begin
      dec_nxt.disp = imm1;
    end else begin
      dec_nxt.disp = 32'h0;
    end
  end

  // Advance when empty or when the next stage takes the held beat
  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      dec_r <= dec_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_dec   = dec_r;

endmodule

### rtl/core/xid_target.sv
`timescale 1ns / 1ps

module xid_target (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  output logic          s_ready,
  input  xid_pkg::dec_t s_dec,
  output logic          m_valid,
  input  logic          m_ready,
  output xid_pkg::res_t m_res
);
  import xid_pkg::*;

  logic valid2_r;
  logic valid3_r;
  dec_t dec2_r;
  dec_t dec2_nxt;
  res_t res_r;
  res_t res_nxt;
  logic ready2;
  logic ready3;

  // Stage two: fall-through address = address + length
  always_comb begin
    dec2_nxt      = s_dec;
    dec2_nxt.addr = s_dec.addr + {29'h0, s_dec.len};
  end

  // Stage three: add the displacement for branches, else pass the operand
  always_comb begin
    res_nxt.code    = dec2_r.code;
    res_nxt.len     = dec2_r.len;
    res_nxt.has     = dec2_r.has;
    res_nxt.operand = dec2_r.branch ? dec2_r.addr + dec2_r.disp : dec2_r.disp;
  end

  assign ready3  = !valid3_r || m_ready;
  assign ready2  = !valid2_r || ready3;
  assign s_ready = ready2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      if (ready2) begin
        valid2_r <= s_valid;
      end
      if (ready3) begin
        valid3_r <= valid2_r;
      end
    end
  end

  // Hold payload while the stage downstream stalls
  always_ff @(posedge clk) begin
    if (ready2 && s_valid) begin
      dec2_r <= dec2_nxt;
    end
    if (ready3 && valid2_r) begin
      res_r <= res_nxt;
    end
  end

  assign m_valid = valid3_r;
  assign m_res   = res_r;

endmodule

### rtl/core/x86_subset_instruction_decoder.sv
`timescale 1ns / 1ps
// Channel  | Direction | Ports                          | Contents
// in_      | sink      | in_tvalid/in_tready/in_tdata   | code window, bytes left, address
// out_     | source    | out_tvalid/out_tready/out_tdata| code, length, operand, flag
//
// Each input beat passes the classify, fall-through and target registers in turn.
// One beat per cycle is sustained unless out_tready stalls; the two 32-bit
// adds (address + length, then + displacement) sit in separate stages after
// the opcode match. Synchronous active-low reset clears the stage valid bits only.
// A stall holds each full stage; empty stages keep filling so bubbles close.

module x86_subset_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // byte_0[7:0], byte_1[15:8], byte_2[23:16], byte_3[31:24], byte_4[39:32],
  // byte_5[47:40], bytes_left[50:48], inst_address[82:51], zero[87:83]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // inst_code[4:0], inst_length[7:5], operand[39:8], has_operand[40], zero[47:41]
  output logic [47:0] out_tdata
);
  import xid_pkg::*;

  win_t win;
  dec_t dec;
  res_t res;
  logic dec_valid;
  logic dec_ready;

  assign win = win_t'(in_tdata[82:0]);

  xid_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_win   (win),
    .m_valid (dec_valid),
    .m_ready (dec_ready),
    .m_dec   (dec)
  );

  xid_target u_target (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dec_valid),
    .s_ready (dec_ready),
    .s_dec   (dec),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_res   (res)
  );

  assign out_tdata = {7'h0, res};

endmodule

### rtl/core/xid_checker.sv
`timescale 1ns / 1ps

module xid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import xid_pkg::*;

  logic  [4:0] code;
  logic  [2:0] len;
  logic [31:0] opnd;
  logic        has;

  assign code = out_tdata[4:0];
  assign len  = out_tdata[7:5];
  assign opnd = out_tdata[39:8];
  assign has  = out_tdata[40];

  // Stalled result beat stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  // Stalled result beat keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed during stall");

  // Only lengths of real forms leave the block
  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (len == 3'd1 || len == 3'd2 || len == 3'd3 ||
                    len == 3'd5 || len == 3'd6))
    else $error("illegal instruction length");

  // Operand flag matches the code class, and register forms carry zero
  a_has_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (has == (code <= IC_JZ)) && (has || opnd == 32'h0))
    else $error("operand flag inconsistent with code");

  // Data bytes are one byte long and carry only the opcode
  a_data_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && code == IC_DATA |-> len == 3'd1 && opnd[31:8] == 24'h0)
    else $error("malformed data byte result");

endmodule

bind x86_subset_instruction_decoder xid_checker u_xid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
